@@ src/sdus_pkg.sv @@
// Shared types and constants of the SDO upload server with serial frame loader.
// Used by every module of the block; no dependencies of its own.

package sdus_pkg;

   // Serial frame layout
   localparam logic [7:0] MARK_HI        = 8'hAA;
   localparam logic [7:0] MARK_LO        = 8'h55;
   localparam logic [7:0] POS_START_HI   = 8'd0;
   localparam logic [7:0] POS_START_LO   = 8'd1;
   localparam logic [7:0] PAYLOAD_FIRST  = 8'd2;
   localparam logic [7:0] PAYLOAD_LAST   = 8'd153;
   localparam logic [7:0] POS_END_LO     = 8'd154;
   localparam logic [7:0] FRAME_LAST     = 8'd155;

   // Command field of an input beat
   localparam logic CMD_SERIAL = 1'b0;

   // SDO command specifiers
   localparam logic [7:0] CS_UPLOAD_REQ  = 8'h40;
   localparam logic [7:0] CS_EXPEDITED   = 8'h43;
   localparam logic [7:0] CS_SEGMENTED   = 8'h41;
   localparam logic [7:0] CS_SEG_REQ     = 8'h4E;
   localparam logic [7:0] CS_SEG_RSP     = 8'h4F;

   // Object dictionary
   localparam logic [15:0] SCALAR_BASE   = 16'h2000;
   localparam logic [15:0] SCALAR_COUNT  = 16'd6;
   localparam logic [15:0] ARRAY_BASE    = 16'h2010;
   localparam logic [15:0] ARRAY_COUNT   = 16'd4;
   localparam logic [31:0] ARRAY_LEN     = 32'd32;
   localparam logic [2:0]  ACTIVE_NONE   = 3'd0;
   localparam logic [2:0]  ACTIVE_MAX    = 3'd4;
   localparam logic [2:0]  SEG_MAX       = 3'd7;
   localparam logic [4:0]  SEG_LAST_FULL = 5'd25;

   // Sample store: 8-byte rows, two banks of 32 row slots (19 used)
   localparam int          ROW_W          = 5;
   localparam int          ADDR_W         = ROW_W + 1;
   localparam int          STORE_DEPTH    = 2 ** ADDR_W;
   localparam logic [4:0]  ROW_ARRAY_BASE = 5'd3;

   // CAN identifier
   localparam logic [10:0] CAN_ID_BASE   = 11'h580;
   localparam logic [6:0]  NODE_ID_RESET = 7'd1;

   // Result kinds
   localparam logic [1:0] KIND_CAN    = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  serial_byte;
      logic [7:0]  req_cs;
      logic [15:0] req_index;
      logic [7:0]  req_sub;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [10:0] can_id;
      logic [63:0] frame_data;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_SCALAR,
      OP_ARRAY,
      OP_SEGMENT,
      OP_FRAME_OK,
      OP_FRAME_BAD
   } op_type;

   // Decoded beat held in the input register
   typedef struct packed {
      op_type      op;
      logic [15:0] index;
      logic [7:0]  sub;
      logic [2:0]  lane;
      logic [2:0]  seg_len;
      logic        data_ok;
   } s1_type;

   // Byte write into the sample store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        lane;
      logic [7:0]        data;
   } wr_type;

endpackage

@@ src/sdo_upload_server_with_serial_loader_unit.sv @@
// SDO upload server with serial frame loader: one beat is taken every clock cycle while
// req_stall is low; each result passes the input register with the store read, then the
// result register. Serial bytes fill a 156-byte frame into the spare bank of a
// double-banked 8-byte-row sample store, so a good frame commits by swapping banks with no
// copy and no clearing pass; until the first good frame the store reads as zero. Depends on
// sdus_pkg, sdus_front, sdus_store, sdus_format.

module sdo_upload_server_with_serial_loader_unit import sdus_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_write,
   input  logic [6:0] csr_wdata
);

   logic              s2_free;
   logic              s1_valid;
   s1_type            s1_info;
   wr_type            wr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [63:0]       rd_data_a;
   logic [63:0]       rd_data_b;

   sdus_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .s2_free   (s2_free),
      .s1_valid  (s1_valid),
      .s1_info   (s1_info),
      .wr        (wr),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b)
   );

   sdus_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sdus_format u_format (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_info   (s1_info),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .s2_free   (s2_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/sdus_store.sv @@
// Double-banked sample store: 8-byte rows, byte write port, two registered read ports.
// Depends on sdus_pkg.

module sdus_store import sdus_pkg::*; (
   input  logic              clock,
   input  wr_type            wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [63:0]       rd_data_a,
   output logic [63:0]       rd_data_b
);

   logic [63:0] mem_ff [STORE_DEPTH];
   logic [63:0] rd_a_ff;
   logic [63:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/sdus_front.sv @@
// Input stage: frame loader state, SDO request decode, store addressing, input register.
// Depends on sdus_pkg.

module sdus_front import sdus_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   input  logic              s2_free,
   output logic              s1_valid,
   output s1_type            s1_info,
   output wr_type            wr,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr_a,
   output logic [ADDR_W-1:0] rd_addr_b
);

   logic [7:0]  byte_position_ff, byte_position_in;
   logic        good_ff, good_in;
   logic        bank_ff, bank_in;
   logic        store_valid_ff, store_valid_in;
   logic [4:0]  seg_off_ff, seg_off_in;
   logic [2:0]  active_ff, active_in;
   logic        s1_valid_ff, s1_valid_in;
   s1_type      s1_ff, s1_in;

   logic        s1_load;
   logic        accept;
   logic [7:0]  pay_pos;
   logic [15:0] sc_off;
   logic [15:0] ar_off;
   logic [1:0]  arr_k;
   logic [4:0]  seg_tail;
   logic [2:0]  seg_len;
   logic [4:0]  row_a;
   logic        is_last;
   logic        frame_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         good_ff          <= 1'b0;
         bank_ff          <= 1'b0;
         store_valid_ff   <= 1'b0;
         seg_off_ff       <= '0;
         active_ff        <= ACTIVE_NONE;
         s1_valid_ff      <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         good_ff          <= good_in;
         bank_ff          <= bank_in;
         store_valid_ff   <= store_valid_in;
         seg_off_ff       <= seg_off_in;
         active_ff        <= active_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   always_comb begin
      s1_load = !s1_valid_ff || s2_free;
      accept  = req_valid && s1_load;

      byte_position_in = byte_position_ff;
      good_in          = good_ff;
      bank_in          = bank_ff;
      store_valid_in   = store_valid_ff;
      seg_off_in       = seg_off_ff;
      active_in        = active_ff;
      s1_valid_in      = s1_load ? 1'b0 : s1_valid_ff;
      s1_in            = s1_ff;
      wr               = '0;

      pay_pos  = byte_position_ff - PAYLOAD_FIRST;
      sc_off   = req_data.req_index - SCALAR_BASE;
      ar_off   = req_data.req_index - ARRAY_BASE;
      arr_k    = 2'(active_ff - 3'd1);
      seg_tail = 5'd0 - seg_off_ff;
      seg_len  = (seg_off_ff > SEG_LAST_FULL) ? seg_tail[2:0] : SEG_MAX;
      row_a    = ROW_ARRAY_BASE + {1'b0, arr_k, 2'b00} + {3'b000, seg_off_ff[4:3]};
      is_last  = byte_position_ff >= FRAME_LAST;
      frame_ok = good_ff && (req_data.serial_byte == MARK_HI);

      if (accept) begin
         s1_in.index   = req_data.req_index;
         s1_in.sub     = req_data.req_sub;
         s1_in.data_ok = store_valid_ff;
         s1_in.lane    = '0;
         s1_in.seg_len = '0;
         s1_in.op      = OP_FRAME_BAD;
         if (req_data.cmd == CMD_SERIAL) begin
            if (byte_position_ff == POS_START_HI) begin
               good_in = req_data.serial_byte == MARK_HI;
            end else if (byte_position_ff == POS_START_LO ||
                         byte_position_ff == POS_END_LO) begin
               good_in = good_ff && (req_data.serial_byte == MARK_LO);
            end
            // payload goes to the bank not being served
            if (byte_position_ff >= PAYLOAD_FIRST && byte_position_ff <= PAYLOAD_LAST) begin
               wr.en   = 1'b1;
               wr.addr = {~bank_ff, pay_pos[7:3]};
               wr.lane = pay_pos[2:0];
               wr.data = req_data.serial_byte;
            end
            if (is_last) begin
               byte_position_in = '0;
               s1_valid_in      = 1'b1;
               s1_in.op         = frame_ok ? OP_FRAME_OK : OP_FRAME_BAD;
               if (frame_ok) begin
                  // commit: swap banks
                  bank_in        = ~bank_ff;
                  store_valid_in = 1'b1;
               end
            end else begin
               byte_position_in = byte_position_ff + 8'd1;
            end
         end else if (req_data.req_cs == CS_UPLOAD_REQ) begin
            if (sc_off < SCALAR_COUNT) begin
               row_a       = {3'b000, sc_off[2:1]};
               s1_valid_in = 1'b1;
               s1_in.op    = OP_SCALAR;
               s1_in.lane  = {sc_off[0], 2'b00};
            end else if (ar_off < ARRAY_COUNT) begin
               active_in   = 3'(ar_off[1:0]) + 3'd1;
               s1_valid_in = 1'b1;
               s1_in.op    = OP_ARRAY;
            end
         end else if (req_data.req_cs == CS_SEG_REQ &&
                      active_ff != ACTIVE_NONE && active_ff <= ACTIVE_MAX) begin
            s1_valid_in   = 1'b1;
            s1_in.op      = OP_SEGMENT;
            s1_in.lane    = seg_off_ff[2:0];
            s1_in.seg_len = seg_len;
            // short segment ends the transfer
            seg_off_in    = (seg_len != SEG_MAX) ? 5'd0 : seg_off_ff + 5'(SEG_MAX);
         end
      end

      rd_en     = s1_load;
      rd_addr_a = {bank_ff, row_a};
      rd_addr_b = {bank_ff, row_a + 5'd1};
   end

   assign req_stall = !s1_load;
   assign s1_valid  = s1_valid_ff;
   assign s1_info   = s1_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) byte_position_ff <= FRAME_LAST)
      else $error("byte position ran past the end of the frame");
   assert property (@(posedge clock) disable iff (reset) active_ff <= ACTIVE_MAX)
      else $error("selected array out of range");
   assert property (@(posedge clock) disable iff (reset) req_stall |-> s1_valid_ff)
      else $error("stall raised with an empty input register");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.cmd == CMD_SERIAL && byte_position_ff >= FRAME_LAST
       && good_ff && req_data.serial_byte == MARK_HI) |=> (bank_ff != $past(bank_ff)))
      else $error("good frame did not swap banks");
`endif

endmodule

@@ src/sdus_format.sv @@
// Result stage: builds the response frame from the input register and store read data,
// holds the node id register and the output register. Depends on sdus_pkg.

module sdus_format import sdus_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        s1_valid,
   input  s1_type      s1_info,
   input  logic [63:0] rd_data_a,
   input  logic [63:0] rd_data_b,
   input  logic        csr_write,
   input  logic [6:0]  csr_wdata,
   output logic        s2_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic [6:0]   node_id_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic [127:0] pair;
   logic [127:0] shifted;
   logic [55:0]  win;
   logic [55:0]  seg_bytes;
   logic [31:0]  head;
   logic [10:0]  can_id;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff   <= NODE_ID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            node_id_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      s2_free      = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = s2_free ? s1_valid : rsp_valid_ff;

      pair    = {rd_data_b, rd_data_a};
      shifted = pair >> {s1_info.lane, 3'b000};
      // store never committed: reads as zero
      win     = s1_info.data_ok ? shifted[55:0] : 56'd0;
      for (int i = 0; i < 7; i++) begin
         seg_bytes[8*i +: 8] = (3'(i) < s1_info.seg_len) ? win[8*i +: 8] : 8'h00;
      end

      head   = {s1_info.sub, s1_info.index[15:8], s1_info.index[7:0], 8'h00};
      can_id = CAN_ID_BASE + 11'(node_id_ff);
      rsp_in = '0;

      case (s1_info.op)
         OP_SCALAR: begin
            rsp_in.result_kind = KIND_CAN;
            rsp_in.can_id      = can_id;
            rsp_in.frame_data  = {win[31:0], head[31:8], CS_EXPEDITED};
         end
         OP_ARRAY: begin
            rsp_in.result_kind = KIND_CAN;
            rsp_in.can_id      = can_id;
            rsp_in.frame_data  = {ARRAY_LEN, head[31:8], CS_SEGMENTED};
         end
         OP_SEGMENT: begin
            rsp_in.result_kind = KIND_CAN;
            rsp_in.can_id      = can_id;
            rsp_in.frame_data  = {seg_bytes, CS_SEG_RSP};
         end
         OP_FRAME_OK: begin
            rsp_in.result_kind = KIND_ACCEPT;
         end
         default: begin
            rsp_in.result_kind = KIND_REJECT;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind != KIND_CAN) |->
      (rsp_data.can_id == 11'd0 && rsp_data.frame_data == 64'd0))
      else $error("frame status beat carries CAN payload");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_CAN) |->
      (rsp_data.can_id == CAN_ID_BASE + 11'(node_id_ff)))
      else $error("response identifier does not match node id");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.result_kind == KIND_CAN || rsp_data.result_kind == KIND_ACCEPT
                     || rsp_data.result_kind == KIND_REJECT))
      else $error("undefined result kind");
`endif

endmodule
